/* rtl/bigsize_tlv_hop_payload_parser_assert.svh */
// assertion macros used by the checker file
`ifndef BIGSIZE_TLV_HOP_PAYLOAD_PARSER_ASSERT_SVH
`define BIGSIZE_TLV_HOP_PAYLOAD_PARSER_ASSERT_SVH

// checked on every clock edge while out of reset
`define BTHP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bthp check failed");

// checked on every clock edge, reset included
`define BTHP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bthp check failed");

`endif

/* rtl/bthp_pkg.sv */
// types and constants of the bigsize tlv hop payload parser
package bthp_pkg;

    localparam int KEY_BYTES  = 33;
    localparam int IDX_W      = 6;
    localparam int BANK_W     = 3;
    localparam int NBANKS     = 1 << BANK_W;
    localparam int RAM_AW     = BANK_W + IDX_W;
    localparam int RAM_DEPTH  = 1 << RAM_AW;
    localparam int FIFO_DEPTH = 2;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(KEY_BYTES - 1);
    localparam logic [IDX_W-1:0] KEY_LEN_I = IDX_W'(KEY_BYTES);

    localparam logic [7:0] PFX_U16 = 8'hfd;
    localparam logic [7:0] PFX_U32 = 8'hfe;
    localparam logic [7:0] PFX_U64 = 8'hff;

    localparam logic [3:0] VLEN_U16 = 4'd2;
    localparam logic [3:0] VLEN_U32 = 4'd4;
    localparam logic [3:0] VLEN_U64 = 4'd8;

    localparam logic [63:0] TYPE_AMT = 64'd2;
    localparam logic [63:0] TYPE_HGT = 64'd4;
    localparam logic [63:0] TYPE_KEY = 64'h0e;

    localparam logic [63:0] LEN_AMT = 64'd8;
    localparam logic [63:0] LEN_HGT = 64'd4;
    localparam logic [63:0] LEN_KEY = 64'(KEY_BYTES);

    localparam logic [2:0] SHORT_MIN = 3'd4;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SKIP = 2'd0,
        KIND_AMT  = 2'd1,
        KIND_HGT  = 2'd2,
        KIND_KEY  = 2'd3
    } kind_t;

    // what one finished payload hands to the result side
    typedef struct packed {
        logic [63:0]       amount;
        logic [31:0]       height;
        logic              ok;
        logic              key_on;
        logic [BANK_W-1:0] bank;
    } summary_t;

    typedef struct packed {
        logic              valid;
        logic [BANK_W-1:0] bank;
    } release_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } key_wr_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } key_rd_t;

    typedef struct packed {
        logic [63:0]      amount;
        logic [31:0]      height;
        logic             ok;
        logic             key_on;
        logic [IDX_W-1:0] index;
        logic             last;
    } out_meta_t;

endpackage

/* rtl/bthp_ram.sv */
// generic single write port ram with registered read
module bthp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bthp_fifo.sv */
// two entry queue of payload summaries between parser and result side
module bthp_fifo
    import bthp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  summary_t push_data,
    output logic     full,
    input  logic     pop,
    output summary_t head,
    output logic     head_valid
);

    summary_t   ent_reg [FIFO_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == 2'(FIFO_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

endmodule

/* rtl/bthp_front.sv */
// byte parser: bigsize type and length, record values, key bank bookkeeping
module bthp_front
    import bthp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic [7:0] data_byte,
    input  logic     last_byte,
    output logic     push,
    output summary_t push_data,
    input  logic     fifo_full,
    output key_wr_t  key_wr,
    input  release_t back_rel
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         vleft_reg, vleft_next;
    logic [63:0]        vacc_reg, vacc_next;
    kind_t              kind_reg, kind_next;
    logic [63:0]        vbl_reg, vbl_next;
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        amt_reg, amt_next;
    logic [31:0]        hgt_reg, hgt_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [BANK_W-1:0]  stage_bank_reg, stage_bank_next;
    logic [BANK_W-1:0]  comm_bank_reg, comm_bank_next;
    logic               kvalid_reg, kvalid_next;
    logic [NBANKS-1:0]  busy_reg, busy_next;
    summary_t           sum_next;

    logic               in_fire;
    logic [BANK_W-1:0]  free_bank;

    assign in_stall = fifo_full;
    assign in_fire  = in_valid && !fifo_full;

    // lowest bank nobody holds; at most five are ever held
    always_comb
    begin
        free_bank = '0;
        for (int i = NBANKS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_bank = BANK_W'(i);
            end
        end
    end

    always_comb
    begin
        logic [63:0]       v;
        logic              vdone;
        logic              key_commit;
        logic              full;
        logic [NBANKS-1:0] set_mask;
        logic [NBANKS-1:0] rel_mask;

        phase_next      = phase_reg;
        vleft_next      = vleft_reg;
        vacc_next       = vacc_reg;
        kind_next       = kind_reg;
        vbl_next        = vbl_reg;
        acc_next        = acc_reg;
        amt_next        = amt_reg;
        hgt_next        = hgt_reg;
        cnt_next        = cnt_reg;
        stage_bank_next = stage_bank_reg;
        comm_bank_next  = comm_bank_reg;
        kvalid_next     = kvalid_reg;
        sum_next        = '0;
        v               = '0;
        vdone           = 1'b0;
        key_commit      = 1'b0;
        full            = 1'b0;
        set_mask        = '0;
        rel_mask        = '0;

        if (back_rel.valid)
        begin
            rel_mask[back_rel.bank] = 1'b1;
        end

        if (in_fire)
        begin
            if (cnt_reg != SHORT_MIN)
            begin
                cnt_next = cnt_reg + 3'd1;
            end

            if (phase_reg == PH_VAL)
            begin
                if (kind_reg == KIND_AMT || kind_reg == KIND_HGT)
                begin
                    acc_next = {acc_reg[55:0], data_byte};
                end
                vbl_next = vbl_reg - 64'd1;
                if (vbl_reg == 64'd1)
                begin
                    case (kind_reg)
                        KIND_AMT: amt_next = acc_next;
                        KIND_HGT: hgt_next = acc_next[31:0];
                        KIND_KEY: key_commit = 1'b1;
                        default:  ;
                    endcase
                    kind_next  = KIND_SKIP;
                    acc_next   = '0;
                    phase_next = PH_TYPE;
                end
            end
            else
            begin
                if (vleft_reg == 4'd0)
                begin
                    vacc_next = '0;
                    case (data_byte)
                        PFX_U16: vleft_next = VLEN_U16;
                        PFX_U32: vleft_next = VLEN_U32;
                        PFX_U64: vleft_next = VLEN_U64;
                        default:
                        begin
                            v     = {56'd0, data_byte};
                            vdone = 1'b1;
                        end
                    endcase
                end
                else
                begin
                    v          = {vacc_reg[55:0], data_byte};
                    vacc_next  = v;
                    vleft_next = vleft_reg - 4'd1;
                    vdone      = (vleft_reg == 4'd1);
                end

                if (vdone)
                begin
                    vacc_next = '0;
                    if (phase_reg == PH_LEN)
                    begin
                        if (v == 64'd0)
                        begin
                            // empty value closes the record at its length
                            phase_next = PH_TYPE;
                            kind_next  = KIND_SKIP;
                        end
                        else
                        begin
                            if ((kind_reg == KIND_AMT && v != LEN_AMT) ||
                                (kind_reg == KIND_HGT && v != LEN_HGT) ||
                                (kind_reg == KIND_KEY && v != LEN_KEY))
                            begin
                                kind_next = KIND_SKIP;
                            end
                            vbl_next   = v;
                            acc_next   = '0;
                            phase_next = PH_VAL;
                        end
                    end
                    else
                    begin
                        case (v)
                            TYPE_AMT: kind_next = KIND_AMT;
                            TYPE_HGT: kind_next = KIND_HGT;
                            TYPE_KEY: kind_next = KIND_KEY;
                            default:  kind_next = KIND_SKIP;
                        endcase
                        phase_next = PH_LEN;
                    end
                end
            end

            // committing a key just renames the staging bank
            if (key_commit)
            begin
                if (kvalid_reg)
                begin
                    rel_mask[comm_bank_reg] = 1'b1;
                end
                comm_bank_next          = stage_bank_reg;
                kvalid_next             = 1'b1;
                stage_bank_next         = free_bank;
                set_mask[free_bank]     = 1'b1;
            end

            if (last_byte)
            begin
                full            = (cnt_next == SHORT_MIN);
                sum_next.amount = full ? amt_next : 64'd0;
                sum_next.height = full ? hgt_next : 32'd0;
                sum_next.ok     = full && (amt_next != 64'd0 || hgt_next != 32'd0);
                sum_next.key_on = full && kvalid_next;
                sum_next.bank   = comm_bank_next;
                // a key of a short payload is never read out
                if (kvalid_next && !full)
                begin
                    rel_mask[comm_bank_next] = 1'b1;
                end
                phase_next  = PH_TYPE;
                vleft_next  = '0;
                vacc_next   = '0;
                kind_next   = KIND_SKIP;
                vbl_next    = '0;
                acc_next    = '0;
                amt_next    = '0;
                hgt_next    = '0;
                cnt_next    = '0;
                kvalid_next = 1'b0;
            end
        end

        busy_next = (busy_reg | set_mask) & ~rel_mask;
    end

    always_comb
    begin
        push         = in_fire && last_byte;
        push_data    = sum_next;
        key_wr.en    = in_fire && (phase_reg == PH_VAL) && (kind_reg == KIND_KEY);
        key_wr.addr  = {stage_bank_reg, KEY_LEN_I - vbl_reg[IDX_W-1:0]};
        key_wr.data  = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TYPE;
            vleft_reg      <= '0;
            vacc_reg       <= '0;
            kind_reg       <= KIND_SKIP;
            vbl_reg        <= '0;
            acc_reg        <= '0;
            amt_reg        <= '0;
            hgt_reg        <= '0;
            cnt_reg        <= '0;
            stage_bank_reg <= '0;
            comm_bank_reg  <= '0;
            kvalid_reg     <= 1'b0;
            busy_reg       <= NBANKS'(1);
        end
        else
        begin
            phase_reg      <= phase_next;
            vleft_reg      <= vleft_next;
            vacc_reg       <= vacc_next;
            kind_reg       <= kind_next;
            vbl_reg        <= vbl_next;
            acc_reg        <= acc_next;
            amt_reg        <= amt_next;
            hgt_reg        <= hgt_next;
            cnt_reg        <= cnt_next;
            stage_bank_reg <= stage_bank_next;
            comm_bank_reg  <= comm_bank_next;
            kvalid_reg     <= kvalid_next;
            busy_reg       <= busy_next;
        end
    end

endmodule

/* rtl/bthp_back.sv */
// result side: walks the key bank of one summary and emits one beat per key byte
module bthp_back
    import bthp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  summary_t         head,
    input  logic             head_valid,
    output logic             pop,
    output key_rd_t          key_rd,
    input  logic [7:0]       ram_q,
    output release_t         rel,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [63:0]      amount,
    output logic [31:0]      lock_height,
    output logic             payload_ok,
    output logic [7:0]       key_byte,
    output logic [IDX_W-1:0] key_index,
    output logic             last_result
);

    logic             cur_valid_reg, cur_valid_next;
    summary_t         cur_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             s1_valid_reg, s1_valid_next;
    out_meta_t        s1_reg;
    logic             ov_reg, ov_next;
    out_meta_t        om_reg;
    logic [7:0]       ok_byte_reg;

    logic advance_out;
    logic s1_free;
    logic issue;
    logic done;

    assign advance_out = !ov_reg || !out_stall;
    assign s1_free     = !s1_valid_reg || advance_out;
    assign issue       = cur_valid_reg && s1_free;
    assign done        = issue && (idx_reg == LAST_IDX);
    assign pop         = head_valid && (!cur_valid_reg || done);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        s1_valid_next  = s1_valid_reg;
        ov_next        = ov_reg;
        if (issue)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (done)
        begin
            cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        if (s1_free)
        begin
            s1_valid_next = issue;
        end
        if (advance_out)
        begin
            ov_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        key_rd.en   = issue;
        key_rd.addr = {cur_reg.bank, idx_reg};
        rel.valid   = done && cur_reg.key_on;
        rel.bank    = cur_reg.bank;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (issue)
        begin
            s1_reg.amount <= cur_reg.amount;
            s1_reg.height <= cur_reg.height;
            s1_reg.ok     <= cur_reg.ok;
            s1_reg.key_on <= cur_reg.key_on;
            s1_reg.index  <= idx_reg;
            s1_reg.last   <= (idx_reg == LAST_IDX);
        end
        if (advance_out && s1_valid_reg)
        begin
            om_reg      <= s1_reg;
            ok_byte_reg <= s1_reg.key_on ? ram_q : 8'd0;
        end
    end

    assign out_valid   = ov_reg;
    assign amount      = om_reg.amount;
    assign lock_height = om_reg.height;
    assign payload_ok  = om_reg.ok;
    assign key_byte    = ok_byte_reg;
    assign key_index   = om_reg.index;
    assign last_result = om_reg.last;

endmodule

/* rtl/bigsize_tlv_hop_payload_parser.sv */
// top level of the bigsize tlv hop payload parser
//
// input channel: one payload byte per beat on data_byte, last_byte high on the
// final byte. records are bigsize type, bigsize length, value; type 2 length 8
// sets the amount, type 4 length 4 the lock height, type 14 length 33 the key.
// output channel: after the last byte, 33 beats, key_index 0 to 32, each with
// amount, lock_height, payload_ok and one key_byte; last_result marks beat 32.
// throughput: one input byte per cycle unless the queue is full, set by the
// single parser register stage; the result side gives one beat per cycle
// unless out_stall holds it, one key ram read each. after the last byte the
// beats pass the queue, summary register, key ram read and output register.
// the parser feeds a 2-entry summary queue; in_stall rises only while both
// entries wait, so a payload can be parsed while the previous one drains.
// key bytes live in 8 ram banks of 64 bytes; a commit renames a bank.
// reset: all parse state clears, no beats pending, the queue empties.
// a stalled output beat holds until taken; upstream stalls spread back only
// through the full queue.
module bigsize_tlv_hop_payload_parser
    import bthp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [63:0]      amount,
    output logic [31:0]      lock_height,
    output logic             payload_ok,
    output logic [7:0]       key_byte,
    output logic [IDX_W-1:0] key_index,
    output logic             last_result
);

    logic     push;
    summary_t push_data;
    logic     fifo_full;
    logic     pop;
    summary_t head;
    logic     head_valid;
    key_wr_t  key_wr;
    key_rd_t  key_rd;
    logic [7:0] ram_q;
    release_t back_rel;

    bthp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full),
        .key_wr    (key_wr),
        .back_rel  (back_rel)
    );

    bthp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    bthp_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr.en),
        .wr_addr (key_wr.addr),
        .wr_data (key_wr.data),
        .rd_en   (key_rd.en),
        .rd_addr (key_rd.addr),
        .rd_data (ram_q)
    );

    bthp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .key_rd      (key_rd),
        .ram_q       (ram_q),
        .rel         (back_rel),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .amount      (amount),
        .lock_height (lock_height),
        .payload_ok  (payload_ok),
        .key_byte    (key_byte),
        .key_index   (key_index),
        .last_result (last_result)
    );

endmodule

/* rtl/bthp_checker.sv */
// port level checks of the parser output, bound to the top level
`include "bigsize_tlv_hop_payload_parser_assert.svh"

module bthp_checker
    import bthp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [7:0]       data_byte,
    input logic             last_byte,
    input logic             out_valid,
    input logic             out_stall,
    input logic [63:0]      amount,
    input logic [31:0]      lock_height,
    input logic             payload_ok,
    input logic [7:0]       key_byte,
    input logic [IDX_W-1:0] key_index,
    input logic             last_result
);

    // a stalled beat stays offered
    `BTHP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

    // a stalled beat keeps its amount, key byte and key index
    `BTHP_ASSERT(a_out_stable, out_valid && out_stall |=> $stable({amount, key_byte, key_index}))

    // last_result marks exactly the final key position
    `BTHP_ASSERT(a_last_idx, out_valid |-> (last_result == (key_index == LAST_IDX)))

    // ok needs a nonzero amount or lock height
    `BTHP_ASSERT(a_ok_value, out_valid && payload_ok |-> (amount != 64'd0 || lock_height != 32'd0))

    // nothing offered while in reset
    `BTHP_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid)

endmodule

bind bigsize_tlv_hop_payload_parser bthp_checker u_bthp_checker (.*);

/* tb/sv/tb_bigsize_tlv_hop_payload_parser.sv */
// self-checking testbench of the bigsize tlv hop payload parser
`timescale 1ns / 100ps

module tb_bigsize_tlv_hop_payload_parser
    import bthp_pkg::*;
();

    localparam int RANDOM_BYTES = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 10;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 40;

    // bigsize encodings, shortest first
    localparam int FORM_DIRECT = 0;
    localparam int FORM_U16    = 1;
    localparam int FORM_U32    = 2;
    localparam int FORM_U64    = 3;

    typedef struct packed {
        logic [63:0]      amount;
        logic [31:0]      height;
        logic             ok;
        logic [7:0]       key;
        logic [IDX_W-1:0] index;
        logic             last;
    } hop_beat_t;

    // tracks the tlv stream byte by byte and holds the beats each payload owes
    class tlv_hop_decoder;
        phase_t      phase;
        kind_t       kind;
        logic [3:0]  prefix_left;
        logic [63:0] prefix_acc;
        logic [63:0] val_left;
        logic [63:0] val_acc;
        logic [7:0]  staged[KEY_BYTES];
        logic [7:0]  key[KEY_BYTES];
        logic [63:0] amt;
        logic [31:0] hgt;
        logic [2:0]  seen;
        hop_beat_t   beats_due[$];
        int errors;
        int beats_checked;
        int payloads;
        int short_payloads;
        int amt_commits;
        int hgt_commits;
        int key_commits;

        function new();
            errors = 0;
            beats_checked = 0;
            payloads = 0;
            short_payloads = 0;
            amt_commits = 0;
            hgt_commits = 0;
            key_commits = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_TYPE;
            kind = KIND_SKIP;
            prefix_left = '0;
            prefix_acc = '0;
            val_left = '0;
            val_acc = '0;
            amt = '0;
            hgt = '0;
            seen = '0;
            for (int i = 0; i < KEY_BYTES; i++)
            begin
                staged[i] = '0;
                key[i] = '0;
            end
        endfunction

        function void end_bigsize();
            logic [63:0] v;
            v = prefix_acc;
            if (phase == PH_LEN)
            begin
                if (v == 0)
                begin
                    // empty value closes the record at its length field
                    phase = PH_TYPE;
                    kind = KIND_SKIP;
                end
                else
                begin
                    if ((kind == KIND_AMT && v != LEN_AMT) ||
                        (kind == KIND_HGT && v != LEN_HGT) ||
                        (kind == KIND_KEY && v != LEN_KEY))
                        kind = KIND_SKIP;
                    val_left = v;
                    val_acc = '0;
                    phase = PH_VAL;
                end
            end
            else
            begin
                if (v == TYPE_AMT)
                    kind = KIND_AMT;
                else if (v == TYPE_HGT)
                    kind = KIND_HGT;
                else if (v == TYPE_KEY)
                    kind = KIND_KEY;
                else
                    kind = KIND_SKIP;
                phase = PH_LEN;
            end
            prefix_acc = '0;
        endfunction

        function void bigsize_byte(logic [7:0] b);
            if (prefix_left == 0)
            begin
                prefix_acc = '0;
                if (b < PFX_U16)
                begin
                    prefix_acc = {56'd0, b};
                    end_bigsize();
                end
                else if (b == PFX_U16)
                    prefix_left = VLEN_U16;
                else if (b == PFX_U32)
                    prefix_left = VLEN_U32;
                else
                    prefix_left = VLEN_U64;
            end
            else
            begin
                prefix_acc = {prefix_acc[55:0], b};
                prefix_left--;
                if (prefix_left == 0)
                    end_bigsize();
            end
        endfunction

        function void value_byte(logic [7:0] b);
            if (kind == KIND_AMT || kind == KIND_HGT)
                val_acc = {val_acc[55:0], b};
            else if (kind == KIND_KEY && val_left >= 1 && val_left <= LEN_KEY)
                staged[KEY_BYTES - int'(val_left)] = b;
            val_left--;
            if (val_left == 0)
            begin
                if (kind == KIND_AMT)
                begin
                    amt = val_acc;
                    amt_commits++;
                end
                else if (kind == KIND_HGT)
                begin
                    hgt = val_acc[31:0];
                    hgt_commits++;
                end
                else if (kind == KIND_KEY)
                begin
                    key = staged;
                    key_commits++;
                end
                kind = KIND_SKIP;
                val_acc = '0;
                phase = PH_TYPE;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic lst);
            hop_beat_t want;
            logic full;
            if (seen < SHORT_MIN)
                seen++;
            if (phase == PH_VAL)
                value_byte(b);
            else
                bigsize_byte(b);
            if (lst)
            begin
                full = (seen >= SHORT_MIN);
                payloads++;
                if (!full)
                    short_payloads++;
                for (int k = 0; k < KEY_BYTES; k++)
                begin
                    want.amount = full ? amt : '0;
                    want.height = full ? hgt : '0;
                    want.ok     = full && (amt != 0 || hgt != 0);
                    want.key    = full ? key[k] : '0;
                    want.index  = IDX_W'(k);
                    want.last   = (k == KEY_BYTES - 1);
                    beats_due.push_back(want);
                end
                restart();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_beat(hop_beat_t got);
            hop_beat_t want;
            if (beats_due.size() == 0)
            begin
                report($sformatf("result beat with nothing due, key_index %0d", got.index));
                return;
            end
            want = beats_due.pop_front();
            beats_checked++;
            if (got.amount !== want.amount)
                report($sformatf("beat %0d amount %h, want %h",
                    want.index, got.amount, want.amount));
            if (got.height !== want.height)
                report($sformatf("beat %0d lock_height %h, want %h",
                    want.index, got.height, want.height));
            if (got.ok !== want.ok)
                report($sformatf("beat %0d payload_ok %b, want %b",
                    want.index, got.ok, want.ok));
            if (got.key !== want.key)
                report($sformatf("beat %0d key_byte %h, want %h",
                    want.index, got.key, want.key));
            if (got.index !== want.index)
                report($sformatf("key_index %0d, want %0d", got.index, want.index));
            if (got.last !== want.last)
                report($sformatf("beat %0d last_result %b, want %b",
                    want.index, got.last, want.last));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte = '0;
    logic             last_byte = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [63:0]      amount;
    logic [31:0]      lock_height;
    logic             payload_ok;
    logic [7:0]       key_byte;
    logic [IDX_W-1:0] key_index;
    logic             last_result;

    tlv_hop_decoder dec = new();
    logic [7:0] pkt[$];
    bit burst = 1'b0;
    int bytes_sent = 0;

    bigsize_tlv_hop_payload_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .amount      (amount),
        .lock_height (lock_height),
        .payload_ok  (payload_ok),
        .key_byte    (key_byte),
        .key_index   (key_index),
        .last_result (last_result)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_form();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(FORM_U64, FORM_DIRECT)
                                           : FORM_DIRECT;
    endfunction

    // a form shorter than the value needs falls back to the shortest that fits
    function automatic void add_bigsize(logic [63:0] v, int form);
        int lo;
        int nb;
        lo = (v < 64'hfd) ? FORM_DIRECT : (v < 64'h1_0000) ? FORM_U16 :
             (v < 64'h1_0000_0000) ? FORM_U32 : FORM_U64;
        if (form < lo)
            form = lo;
        case (form)
            FORM_DIRECT: nb = 0;
            FORM_U16:    nb = 2;
            FORM_U32:    nb = 4;
            default:     nb = 8;
        endcase
        case (form)
            FORM_DIRECT: pkt.push_back(v[7:0]);
            FORM_U16:    pkt.push_back(PFX_U16);
            FORM_U32:    pkt.push_back(PFX_U32);
            default:     pkt.push_back(PFX_U64);
        endcase
        for (int i = nb - 1; i >= 0; i--)
            pkt.push_back(v[8*i +: 8]);
    endfunction

    // fill below zero means random bytes
    function automatic void add_value(int n, int fill);
        for (int i = 0; i < n; i++)
            pkt.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    endfunction

    function automatic void add_record(logic [63:0] ty, int len, int ty_form,
                                       int len_form, int fill);
        add_bigsize(ty, ty_form);
        add_bigsize(64'(len), len_form);
        add_value(len, fill);
    endfunction

    function automatic void drop_tail(int n);
        while (n > 0 && pkt.size() > 1)
        begin
            void'(pkt.pop_back());
            n--;
        end
    endfunction

    function automatic logic [63:0] other_type();
        logic [63:0] t;
        t = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                        : 64'($urandom_range(0, 300));
        if (t == TYPE_AMT || t == TYPE_HGT || t == TYPE_KEY)
            t = t + 1;
        return t;
    endfunction

    function automatic void add_random_record();
        int pick;
        int len;
        int fill;
        logic [63:0] ty;
        pick = $urandom_range(0, 9);
        fill = ($urandom_range(0, 5) == 0) ? 0 : -1;
        case (pick)
            0, 1, 2: add_record(TYPE_AMT, 8, pick_form(), pick_form(), fill);
            3, 4:    add_record(TYPE_HGT, 4, pick_form(), pick_form(), fill);
            5:       add_record(TYPE_KEY, KEY_BYTES, pick_form(), pick_form(), -1);
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       ty = TYPE_AMT;
                    1:       ty = TYPE_HGT;
                    2:       ty = TYPE_KEY;
                    default: ty = other_type();
                endcase
                add_bigsize(ty, pick_form());
                add_bigsize(64'd0, pick_form());
            end
            7, 8: add_record(other_type(), $urandom_range(0, 6), pick_form(), pick_form(), -1);
            default:
            begin
                // known type with the wrong length is skipped
                case ($urandom_range(0, 2))
                    0:
                    begin
                        ty = TYPE_AMT;
                        len = $urandom_range(1, 12);
                        if (64'(len) == LEN_AMT)
                            len++;
                    end
                    1:
                    begin
                        ty = TYPE_HGT;
                        len = $urandom_range(1, 7);
                        if (64'(len) == LEN_HGT)
                            len--;
                    end
                    default:
                    begin
                        ty = TYPE_KEY;
                        len = $urandom_range(0, 1) ? KEY_BYTES - 1 : KEY_BYTES + 1;
                    end
                endcase
                add_record(ty, len, pick_form(), pick_form(), -1);
            end
        endcase
    endfunction

    task automatic send_byte(logic [7:0] b, logic lst);
        int gap;
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        dec.take_byte(b, lst);
        bytes_sent++;
        gap = burst ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_payload();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    // left is how many bytes the run may still send
    task automatic random_payload(int left);
        int cut;
        if ($urandom_range(0, 9) == 0)
            add_value($urandom_range(1, 8), -1);
        else
            repeat ($urandom_range(1, 4)) add_random_record();
        // cut the stream short now and then
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, pkt.size());
            drop_tail(pkt.size() - cut);
        end
        if (pkt.size() > left)
            drop_tail(pkt.size() - left);
        burst = ($urandom_range(0, 3) == 0);
        send_payload();
    endtask

    // receiver: checks every taken beat, stalls at random, holds off once
    initial
    begin
        hop_beat_t got;
        int hold_left;
        int stall_left;
        int run_left;
        bit hold_done;
        hold_left = 0;
        stall_left = 0;
        run_left = 0;
        hold_done = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && !out_stall)
                begin
                    got.amount = amount;
                    got.height = lock_height;
                    got.ok     = payload_ok;
                    got.key    = key_byte;
                    got.index  = key_index;
                    got.last   = last_result;
                    dec.check_beat(got);
                end
                if (!hold_done && dec.beats_checked >= HOLD_AFTER)
                begin
                    // long hold so the summary queue fills and the input stalls
                    hold_done = 1;
                    hold_left = HOLD_CYCLES;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    out_stall <= 1'b1;
                end
                else if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    if (run_left > 0)
                        run_left--;
                    else
                    begin
                        stall_left = gap_len();
                        run_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("no beat moved for %0d cycles, %0d beats still due",
            IDLE_LIMIT, dec.beats_due.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int directed_bytes;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short payloads: one byte, then three
        pkt.push_back(TYPE_AMT[7:0]);
        send_payload();
        add_record(TYPE_HGT, 1, FORM_DIRECT, FORM_DIRECT, 8'hff);
        send_payload();

        // largest values, non-canonical bigsize and a full key
        add_record(TYPE_AMT, 8, FORM_DIRECT, FORM_U32, 8'hff);
        add_record(TYPE_HGT, 4, FORM_U64, FORM_U16, 8'hff);
        add_record(TYPE_KEY, KEY_BYTES, FORM_U16, FORM_DIRECT, -1);
        send_payload();

        // empty, misfit and unknown records skipped, zero values override,
        // then the stream ends inside a bigsize field
        add_record(TYPE_HGT, 4, FORM_DIRECT, FORM_DIRECT, -1);
        add_record(TYPE_AMT, 0, FORM_DIRECT, FORM_DIRECT, -1);
        add_record(TYPE_AMT, 1, FORM_DIRECT, FORM_DIRECT, -1);
        add_record(64'd256, 1, FORM_U16, FORM_DIRECT, -1);
        add_record(TYPE_AMT, 8, FORM_DIRECT, FORM_DIRECT, 0);
        add_record(TYPE_HGT, 4, FORM_DIRECT, FORM_DIRECT, 0);
        pkt.push_back(PFX_U32);
        pkt.push_back(8'h00);
        send_payload();

        // key record cut short inside its value, lock height stays
        add_record(TYPE_HGT, 4, FORM_DIRECT, FORM_DIRECT, -1);
        add_record(TYPE_KEY, KEY_BYTES, FORM_DIRECT, FORM_DIRECT, -1);
        drop_tail(KEY_BYTES - 2);
        send_payload();

        directed_bytes = bytes_sent;
        while (bytes_sent - directed_bytes < RANDOM_BYTES)
            random_payload(RANDOM_BYTES - (bytes_sent - directed_bytes));
        in_valid <= 1'b0;

        while (dec.beats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d payloads (%0d short), %0d bytes, %0d result beats checked",
            dec.payloads, dec.short_payloads, bytes_sent, dec.beats_checked);
        $display("commits: %0d amount, %0d lock height, %0d key; %0d mismatches",
            dec.amt_commits, dec.hgt_commits, dec.key_commits, dec.errors);
        if (dec.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
